// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check prop at every rising clock edge, skipped while rst is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check prop at every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`else

`define ASSERT_CLK_RST(label, clk, rst, prop)
`define ASSERT_CLK(label, clk, prop)

`endif

`endif

// ===== rtl/core/vat_pkg.sv =====
`default_nettype none

package vat_pkg;

   localparam int CoordWidth = 32;
   localparam int FracBits   = 16;
   localparam int CoefWidth  = 18;
   localparam int NumLanes   = 3;

   localparam int ProdAWidth = 2 * CoordWidth;
   localparam int ProdBWidth = CoefWidth + CoordWidth;
   localparam int SumWidth   = ProdAWidth + 2;
   localparam int QuoWidth   = SumWidth - FracBits;
   localparam int RoundHalf  = 1 << (FracBits - 1);

   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 5;

   localparam logic [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth - 1){1'b1}}};
   localparam logic [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth - 1){1'b0}}};

   localparam logic [2:0] ModeRotX      = 3'd0;
   localparam logic [2:0] ModeRotY      = 3'd1;
   localparam logic [2:0] ModeRotZ      = 3'd2;
   localparam logic [2:0] ModeScale     = 3'd3;
   localparam logic [2:0] ModeTranslate = 3'd4;

   localparam logic [2:0] RegMode   = 3'd0;
   localparam logic [2:0] RegCos    = 3'd1;
   localparam logic [2:0] RegSin    = 3'd2;
   localparam logic [2:0] RegScale  = 3'd3;
   localparam logic [2:0] RegOffset = 3'd4;
   localparam logic [2:0] RegAxis   = 3'd5;

   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   localparam logic [1:0] LanePass  = 2'd0;
   localparam logic [1:0] LaneRot   = 2'd1;
   localparam logic [1:0] LaneScale = 2'd2;
   localparam logic [1:0] LaneAdd   = 2'd3;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      logic [2:0]                  transform_mode;
      logic signed [CoefWidth-1:0] cos_term;
      logic signed [CoefWidth-1:0] sin_term;
      logic signed [31:0]          scale_factor;
      logic signed [31:0]          translate_offset;
      logic [1:0]                  translate_axis;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] other_sel;
      logic       neg;
   } lane_op_type;

   function automatic lane_op_type lane_decode(input logic [2:0] mode,
                                               input logic [1:0] axis,
                                               input logic [1:0] lane);
      lane_op_type op;
      op.kind      = LanePass;
      op.other_sel = AxisX;
      op.neg       = 1'b0;
      case (mode)
         ModeRotX: begin
            if (lane == AxisY) begin
               op.kind      = LaneRot;
               op.other_sel = AxisZ;
            end else if (lane == AxisZ) begin
               op.kind      = LaneRot;
               op.other_sel = AxisY;
               op.neg       = 1'b1;
            end
         end
         ModeRotY: begin
            if (lane == AxisX) begin
               op.kind      = LaneRot;
               op.other_sel = AxisZ;
            end else if (lane == AxisZ) begin
               op.kind      = LaneRot;
               op.other_sel = AxisX;
               op.neg       = 1'b1;
            end
         end
         ModeRotZ: begin
            if (lane == AxisX) begin
               op.kind      = LaneRot;
               op.other_sel = AxisY;
               op.neg       = 1'b1;
            end else if (lane == AxisY) begin
               op.kind      = LaneRot;
               op.other_sel = AxisX;
            end
         end
         ModeScale: begin
            op.kind = LaneScale;
         end
         ModeTranslate: begin
            if (axis == lane) begin
               op.kind = LaneAdd;
            end
         end
         default: begin
            op.kind = LanePass;
         end
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vat_csr.sv =====
`default_nettype none

module vat_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vat_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [vat_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [vat_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready,
   output vat_pkg::cfg_type                    cfg
);
   import vat_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[CsrAddrWidth-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            RegMode:   cfg_in.transform_mode   = csr_pwdata[2:0];
            RegCos:    cfg_in.cos_term         = csr_pwdata[CoefWidth-1:0];
            RegSin:    cfg_in.sin_term         = csr_pwdata[CoefWidth-1:0];
            RegScale:  cfg_in.scale_factor     = csr_pwdata[31:0];
            RegOffset: cfg_in.translate_offset = csr_pwdata[31:0];
            RegAxis:   cfg_in.translate_axis   = csr_pwdata[1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transform_mode   <= ModeTranslate;
         cfg_ff.cos_term         <= CoefWidth'(1 << FracBits);
         cfg_ff.sin_term         <= '0;
         cfg_ff.scale_factor     <= 32'(1 << FracBits);
         cfg_ff.translate_offset <= '0;
         cfg_ff.translate_axis   <= AxisX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         RegMode:   csr_prdata = CsrDataWidth'(cfg_ff.transform_mode);
         RegCos:    csr_prdata = CsrDataWidth'(cfg_ff.cos_term);
         RegSin:    csr_prdata = CsrDataWidth'(cfg_ff.sin_term);
         RegScale:  csr_prdata = CsrDataWidth'(cfg_ff.scale_factor);
         RegOffset: csr_prdata = CsrDataWidth'(cfg_ff.translate_offset);
         RegAxis:   csr_prdata = CsrDataWidth'(cfg_ff.translate_axis);
         default:   csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/vat_lane.sv =====
`default_nettype none

module vat_lane (
   input  logic                 clock,
   input  logic                 load,
   input  vat_pkg::lane_op_type op,
   input  vat_pkg::cfg_type     cfg,
   input  vat_pkg::coord_type   own_coord,
   input  vat_pkg::coord_type   other_coord,
   output vat_pkg::coord_type   result
);
   import vat_pkg::*;

   logic signed [CoordWidth-1:0] coef;
   logic signed [ProdAWidth-1:0] prod_a;
   logic signed [ProdAWidth-1:0] own_up;
   logic signed [ProdAWidth-1:0] prod_a_in;
   logic signed [ProdAWidth-1:0] prod_a_ff;
   logic signed [ProdBWidth-1:0] prod_b;
   logic signed [ProdBWidth-1:0] offset_up;
   logic signed [ProdBWidth-1:0] prod_b_in;
   logic signed [ProdBWidth-1:0] prod_b_ff;
   logic                         neg_in;
   logic                         neg_ff;
   logic signed [SumWidth-1:0]   addend;
   logic signed [SumWidth-1:0]   sum;
   logic [QuoWidth-1:0]          quo;

   assign coef      = (op.kind == LaneScale) ? CoordWidth'(cfg.scale_factor)
                                             : CoordWidth'(cfg.cos_term);
   assign prod_a    = ProdAWidth'(coef) * ProdAWidth'(own_coord);
   assign prod_b    = ProdBWidth'(cfg.sin_term) * ProdBWidth'(other_coord);
   assign own_up    = ProdAWidth'(own_coord) <<< FracBits;
   assign offset_up = ProdBWidth'(cfg.translate_offset) <<< FracBits;

   always_comb begin
      prod_a_in = own_up;
      prod_b_in = '0;
      neg_in    = 1'b0;
      case (op.kind)
         LaneRot: begin
            prod_a_in = prod_a;
            prod_b_in = prod_b;
            neg_in    = op.neg;
         end
         LaneScale: begin
            prod_a_in = prod_a;
         end
         LaneAdd: begin
            prod_b_in = offset_up;
         end
         default: begin
            prod_a_in = own_up;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         neg_ff    <= neg_in;
      end
   end

   // Round half up, then clamp to the coordinate range.
   assign addend = neg_ff ? -SumWidth'(prod_b_ff) : SumWidth'(prod_b_ff);
   assign sum    = SumWidth'(prod_a_ff) + addend + SumWidth'(RoundHalf);
   assign quo    = sum[SumWidth-1:FracBits];

   always_comb begin
      if (!quo[QuoWidth-1] && (|quo[QuoWidth-2:CoordWidth-1])) begin
         result = CoordMax;
      end else if (quo[QuoWidth-1] && !(&quo[QuoWidth-2:CoordWidth-1])) begin
         result = CoordMin;
      end else begin
         result = quo[CoordWidth-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/vat_merge.sv =====
`default_nettype none

module vat_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   input  vat_pkg::coord_type lane_result [vat_pkg::NumLanes],
   input  logic               rsp_stall,
   output logic               advance,
   output logic               rsp_valid,
   output vat_pkg::coord_type rsp_out_x,
   output vat_pkg::coord_type rsp_out_y,
   output vat_pkg::coord_type rsp_out_z
);
   import vat_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   coord_type out_ff [NumLanes];

   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         out_ff <= lane_result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_x = out_ff[AxisX];
   assign rsp_out_y = out_ff[AxisY];
   assign rsp_out_z = out_ff[AxisZ];

endmodule

`default_nettype wire

// ===== rtl/core/vertex_affine_transform_unit.sv =====
// Vertex affine transform unit.
// Input channel req_*: one vertex (x, y, z, signed Q16.16) per transaction,
// taken at a rising edge with req_valid high and req_stall low.
// Result channel rsp_*: one transformed vertex per input transaction, in order,
// taken at a rising edge with rsp_valid high and rsp_stall low.
// Configuration is an APB-style port (csr_*): mode, cosine, sine, scale factor,
// translate offset and translate axis at byte addresses 0, 4, ..., 20; pready is
// always high. Write it only while no transaction is in flight.
// A taken vertex passes the lane product registers, then the output register.
// Throughput: one vertex per cycle unless stalled; three lanes, one per output
// coordinate, each with its own multipliers, and a shared output register.
// Stalls: the output register holds while rsp_stall is high; the product stage
// keeps filling, and req_stall rises only when both stages hold a vertex.
// Reset (synchronous, active high) empties the pipeline and restores the
// registers: translate mode, cosine 1.0, sine 0, scale 1.0, offset 0, axis x.
`default_nettype none
`include "assert_macros.svh"

module vertex_affine_transform_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [31:0]               req_vertex_x,
   input  logic signed [31:0]               req_vertex_y,
   input  logic signed [31:0]               req_vertex_z,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [31:0]               rsp_out_x,
   output logic signed [31:0]               rsp_out_y,
   output logic signed [31:0]               rsp_out_z,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [vat_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [vat_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [vat_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready
);
   import vat_pkg::*;

   cfg_type     cfg;
   coord_type   vin [NumLanes];
   coord_type   other [NumLanes];
   coord_type   lane_result [NumLanes];
   lane_op_type lane_op [NumLanes];
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic        s1_open;
   logic        s2_advance;
   logic        lane_load;

   vat_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign vin[AxisX] = req_vertex_x;
   assign vin[AxisY] = req_vertex_y;
   assign vin[AxisZ] = req_vertex_z;

   assign s1_open     = !s1_valid_ff || s2_advance;
   assign req_stall   = !s1_open;
   assign lane_load   = req_valid && s1_open;
   assign s1_valid_in = s1_open ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   for (genvar k = 0; k < NumLanes; k++) begin : g_lane
      always_comb begin
         lane_op[k] = lane_decode(cfg.transform_mode, cfg.translate_axis, 2'(k));
         case (lane_op[k].other_sel)
            AxisX:   other[k] = vin[AxisX];
            AxisY:   other[k] = vin[AxisY];
            AxisZ:   other[k] = vin[AxisZ];
            default: other[k] = '0;
         endcase
      end

      vat_lane u_lane (
         .clock       (clock),
         .load        (lane_load),
         .op          (lane_op[k]),
         .cfg         (cfg),
         .own_coord   (vin[k]),
         .other_coord (other[k]),
         .result      (lane_result[k])
      );
   end

   vat_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (s1_valid_ff),
      .lane_result (lane_result),
      .rsp_stall   (rsp_stall),
      .advance     (s2_advance),
      .rsp_valid   (rsp_valid),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z)
   );

   `ASSERT_CLK(a_reset_empties, clock, reset |=> (!s1_valid_ff && !rsp_valid))
   `ASSERT_CLK_RST(a_accept_fills, clock, reset, (req_valid && !req_stall) |=> s1_valid_ff)
   `ASSERT_CLK_RST(a_stage_holds, clock, reset, (s1_valid_ff && !s2_advance) |=> s1_valid_ff)
   `ASSERT_CLK_RST(a_stall_only_full, clock, reset,
                   req_stall |-> (s1_valid_ff && rsp_valid && rsp_stall))

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vat_pkg::*;

   localparam int Hi         = 32'h7fff_ffff;
   localparam int Lo         = 32'h8000_0000;
   localparam int Unit       = 65536;
   localparam int Half       = 32768;
   localparam int CoefTop    = 131071;
   localparam int CoefBottom = -131072;

   localparam logic [2:0] ModeSpareLo = 3'd5;
   localparam logic [2:0] ModeSpareHi = 3'd7;
   localparam logic [1:0] AxisNone    = 2'd3;

   localparam int RandomBlocks = 38;
   localparam int BlockItems   = 25;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vertex_type;

   typedef struct packed {
      logic [2:0] mode;
      int         coef_cos;
      int         coef_sin;
      int         scale;
      int         offset;
      logic [1:0] axis;
      int         x;
      int         y;
      int         z;
      bit         known;
      int         want_x;
      int         want_y;
      int         want_z;
   } directed_row_type;

   localparam cfg_type ResetCfg = '{ModeTranslate, 18'sd65536, 18'sd0, 32'sd65536, 32'sd0, AxisX};

   directed_row_type directed_table [23] = '{
      '{ModeTranslate, Unit, 0, Unit, 0, AxisX, Hi, Lo, 0, 1'b1, Hi, Lo, 0},
      '{ModeTranslate, Unit, 0, Unit, 0, AxisX, -1, 1, Unit, 1'b1, -1, 1, Unit},
      '{ModeTranslate, Unit, 0, Unit, Hi, AxisX, Hi, -1, Lo, 1'b1, Hi, -1, Lo},
      '{ModeTranslate, Unit, 0, Unit, Lo, AxisY, 5, Lo, Hi, 1'b1, 5, Lo, Hi},
      '{ModeTranslate, Unit, 0, Unit, Unit, AxisZ, 0, 0, 5, 1'b1, 0, 0, Unit + 5},
      '{ModeTranslate, Unit, 0, Unit, Lo, AxisZ, 3, 4, Hi, 1'b1, 3, 4, -1},
      '{ModeTranslate, Unit, 0, Unit, 7, AxisNone, 1, 2, 3, 1'b1, 1, 2, 3},
      '{ModeSpareLo, Unit, 0, Unit, 7, AxisX, Hi, 2, Lo, 1'b1, Hi, 2, Lo},
      '{ModeSpareHi, CoefBottom, CoefTop, Lo, Hi, AxisY, Lo, -1, Hi, 1'b1, Lo, -1, Hi},
      '{ModeScale, Unit, 0, Unit, 0, AxisX, Hi, Lo, -1, 1'b1, Hi, Lo, -1},
      '{ModeScale, Unit, 0, Hi, 0, AxisX, Hi, Lo, 0, 1'b1, Hi, Lo, 0},
      '{ModeScale, Unit, 0, Lo, 0, AxisX, Lo, Hi, 1, 1'b0, 0, 0, 0},
      '{ModeScale, Unit, 0, Half, 0, AxisX, 1, -1, 3, 1'b1, 1, 0, 2},
      '{ModeScale, Unit, 0, 0, 0, AxisX, Hi, Lo, 9, 1'b1, 0, 0, 0},
      '{ModeRotX, Unit, 0, Unit, 0, AxisX, 7, Hi, Lo, 1'b1, 7, Hi, Lo},
      '{ModeRotX, 0, Unit, Unit, 0, AxisX, 7, 5, 9, 1'b1, 7, 9, -5},
      '{ModeRotY, 0, Unit, Unit, 0, AxisX, 5, 7, 9, 1'b1, 9, 7, -5},
      '{ModeRotZ, 0, Unit, Unit, 0, AxisX, 5, 9, 7, 1'b1, -9, 5, 7},
      '{ModeRotX, -Unit, 0, Unit, 0, AxisX, 2, Lo, Hi, 1'b1, 2, Hi, -Hi},
      '{ModeRotX, CoefTop, CoefBottom, Unit, 0, AxisX, 1, Hi, Lo, 1'b0, 0, 0, 0},
      '{ModeRotY, CoefBottom, CoefTop, Unit, 0, AxisX, Lo, 0, Hi, 1'b0, 0, 0, 0},
      '{ModeRotZ, -Unit, -Unit, Unit, 0, AxisX, Hi, Lo, -1, 1'b0, 0, 0, 0},
      '{ModeRotZ, 46341, 46341, Unit, 0, AxisX, Unit, -Unit, Half, 1'b0, 0, 0, 0}
   };

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   coord_type               req_vertex_x = '0;
   coord_type               req_vertex_y = '0;
   coord_type               req_vertex_z = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   coord_type               rsp_out_x;
   coord_type               rsp_out_y;
   coord_type               rsp_out_z;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   logic       stim_known = 1'b0;
   vertex_type stim_want  = '0;

   vertex_type pending_vertices[$];
   cfg_type    cfg_model   = ResetCfg;
   cfg_type    current_cfg = ResetCfg;
   int         items_sent   = 0;
   int         results_seen = 0;
   int         errors       = 0;
   int         idle_pct     = 0;
   int         stall_pct    = 0;

   vertex_affine_transform_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("[vertex_affine_transform_unit] ERROR");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic longint round_q16(longint acc);
      return (acc + RoundHalf) >>> FracBits;
   endfunction

   function automatic coord_type clip_coord(longint v);
      if (v > longint'(Hi)) return CoordMax;
      if (v < longint'(Lo)) return CoordMin;
      return coord_type'(v[31:0]);
   endfunction

   function automatic vertex_type transform_vertex(cfg_type cfg, vertex_type v);
      longint     c;
      longint     s;
      longint     f;
      longint     d;
      longint     p[3];
      longint     q[3];
      vertex_type r;
      c = $signed(cfg.cos_term);
      s = $signed(cfg.sin_term);
      f = $signed(cfg.scale_factor);
      d = $signed(cfg.translate_offset);
      p[0] = v.x;
      p[1] = v.y;
      p[2] = v.z;
      q = p;
      case (cfg.transform_mode)
         ModeRotX: begin
            q[1] = round_q16(c * p[1] + s * p[2]);
            q[2] = round_q16(c * p[2] - s * p[1]);
         end
         ModeRotY: begin
            q[0] = round_q16(c * p[0] + s * p[2]);
            q[2] = round_q16(c * p[2] - s * p[0]);
         end
         ModeRotZ: begin
            q[0] = round_q16(c * p[0] - s * p[1]);
            q[1] = round_q16(s * p[0] + c * p[1]);
         end
         ModeScale: begin
            for (int k = 0; k < NumLanes; k++) q[k] = round_q16(p[k] * f);
         end
         ModeTranslate: begin
            if (cfg.translate_axis <= AxisZ) begin
               q[cfg.translate_axis] = p[cfg.translate_axis] + d;
            end
         end
         default: begin
         end
      endcase
      r.x = clip_coord(q[0]);
      r.y = clip_coord(q[1]);
      r.z = clip_coord(q[2]);
      return r;
   endfunction

   function automatic int random_word();
      case ($urandom_range(3))
         0: return $urandom_range(2097152) - 1048576;
         1: begin
            case ($urandom_range(4))
               0: return Hi;
               1: return Lo;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic int random_coef();
      case ($urandom_range(3))
         1: return $urandom();
         2: begin
            case ($urandom_range(4))
               0: return Unit;
               1: return -Unit;
               2: return 0;
               3: return CoefTop;
               default: return CoefBottom;
            endcase
         end
         default: return $urandom_range(2 * Unit) - Unit;
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type cfg;
      int      sel;
      int      coef;
      sel = $urandom_range(19);
      if (sel < 18) begin
         cfg.transform_mode = 3'(sel % 5);
      end else begin
         cfg.transform_mode = 3'(ModeSpareLo + $urandom_range(2));
      end
      coef = random_coef();
      cfg.cos_term = coef[17:0];
      coef = random_coef();
      cfg.sin_term = coef[17:0];
      cfg.scale_factor = random_word();
      cfg.translate_offset = random_word();
      cfg.translate_axis = 2'($urandom_range(3));
      return cfg;
   endfunction

   task automatic check_field(input string name, input coord_type want, input coord_type got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      vertex_type stim;
      vertex_type got;
      vertex_type want;
      if (reset) begin
         cfg_model = ResetCfg;
         pending_vertices.delete();
      end else begin
         if (req_valid && !req_stall) begin
            stim = '{req_vertex_x, req_vertex_y, req_vertex_z};
            pending_vertices.push_back(stim_known ? stim_want : transform_vertex(cfg_model, stim));
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            got = '{rsp_out_x, rsp_out_y, rsp_out_z};
            if (pending_vertices.size() == 0) begin
               $error("result transaction with no vertex outstanding");
               errors++;
            end else begin
               want = pending_vertices.pop_front();
               check_field("out_x", want.x, got.x);
               check_field("out_y", want.y, got.y);
               check_field("out_z", want.z, got.z);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               RegMode:   cfg_model.transform_mode   = csr_pwdata[2:0];
               RegCos:    cfg_model.cos_term         = csr_pwdata[17:0];
               RegSin:    cfg_model.sin_term         = csr_pwdata[17:0];
               RegScale:  cfg_model.scale_factor     = csr_pwdata;
               RegOffset: cfg_model.translate_offset = csr_pwdata;
               RegAxis:   cfg_model.translate_axis   = csr_pwdata[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // psel stays high across back-to-back writes; the caller closes the burst
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic write_config(input cfg_type next);
      csr_write(RegMode, {29'b0, next.transform_mode});
      csr_write(RegCos, {{14{next.cos_term[17]}}, next.cos_term});
      csr_write(RegSin, {{14{next.sin_term[17]}}, next.sin_term});
      csr_write(RegScale, next.scale_factor);
      csr_write(RegOffset, next.translate_offset);
      csr_write(RegAxis, {30'b0, next.translate_axis});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      current_cfg = next;
   endtask

   task automatic issue_vertex(input vertex_type v, input logic known, input vertex_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_vertex_x <= v.x;
      req_vertex_y <= v.y;
      req_vertex_z <= v.z;
      stim_known   <= known;
      stim_want    <= want;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic flush_pipeline();
      req_valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      directed_row_type row;
      cfg_type          next;
      vertex_type       v;
      vertex_type       want;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) begin
         row = directed_table[i];
         next.transform_mode   = row.mode;
         next.cos_term         = row.coef_cos[17:0];
         next.sin_term         = row.coef_sin[17:0];
         next.scale_factor     = row.scale;
         next.translate_offset = row.offset;
         next.translate_axis   = row.axis;
         if (next != current_cfg) begin
            flush_pipeline();
            write_config(next);
         end
         v    = '{row.x, row.y, row.z};
         want = '{row.want_x, row.want_y, row.want_z};
         issue_vertex(v, row.known, want);
      end

      for (int b = 0; b < RandomBlocks; b++) begin
         flush_pipeline();
         case (b % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 80; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 80; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         write_config(random_cfg());
         for (int k = 0; k < BlockItems; k++) begin
            v = '{random_word(), random_word(), random_word()};
            issue_vertex(v, 1'b0, '0);
         end
      end

      flush_pipeline();
      repeat (4) @(posedge clock);
      if (pending_vertices.size() != 0) begin
         $error("%0d vertices never came back", pending_vertices.size());
         errors++;
      end
      if (errors == 0) begin
         $display("[vertex_affine_transform_unit] OK");
      end else begin
         $display("[vertex_affine_transform_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== vertex_affine_transform_unit.f =====
+incdir+rtl/core
rtl/core/vat_pkg.sv
rtl/core/vat_csr.sv
rtl/core/vat_lane.sv
rtl/core/vat_merge.sv
rtl/core/vertex_affine_transform_unit.sv
verif/tb.sv
